>>> rtl/core/nth_gf2_irreducible_sieve_defines.svh
// Assertion macros shared by the checker files of the GF(2) sieve.
// No dependencies; include by bare file name.
`ifndef NTH_GF2_IRREDUCIBLE_SIEVE_DEFINES_SVH
`define NTH_GF2_IRREDUCIBLE_SIEVE_DEFINES_SVH

// implication checked in the same cycle
`define GF2S_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gf2 sieve check failed");

// implication checked in the next cycle
`define GF2S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gf2 sieve check failed");

`endif

>>> rtl/core/gf2s_pkg.sv
// Shared constants and types for the GF(2) irreducible sieve.
// No dependencies.
package gf2s_pkg;

   localparam int ADDR_BITS  = 16;                 // sieve covers values below 2^ADDR_BITS
   localparam int HALF_BITS  = ADDR_BITS - 1;      // odd values only are stored
   localparam int PROD_BITS  = 2 * ADDR_BITS - 1;  // carry-less product width
   localparam int VALUE_BITS = 16;
   localparam int COUNT_BITS = 17;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [HALF_BITS-1:0]  half_type;
   typedef logic [PROD_BITS-1:0]  prod_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // mark memory write port
   typedef struct packed {
      logic     en;
      half_type addr;
      logic     data;
   } mark_wr_type;

endpackage

>>> rtl/core/gf2s_clmul.sv
// Carry-less (GF(2) polynomial) multiplier, one product per cycle.
// Depends on gf2s_pkg.
module gf2s_clmul
   import gf2s_pkg::*;
(
   input  addr_type a,
   input  addr_type b,
   output prod_type prod
);

   always_comb begin
      prod = '0;
      for (int k = 0; k < ADDR_BITS; k++) begin
         if (b[k]) begin
            prod = prod ^ (PROD_BITS'(a) << k);
         end
      end
   end

endmodule

>>> rtl/core/gf2s_mark_ram.sv
// Candidate mark bitmap, one bit per odd value; one write, one registered read.
// Depends on gf2s_pkg.
module gf2s_mark_ram
   import gf2s_pkg::*;
(
   input  logic        clock,
   input  mark_wr_type wr,
   input  half_type    rd_addr,
   output logic        rd_data_ff
);

   logic mem [2**HALF_BITS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

>>> rtl/core/nth_gf2_irreducible_sieve.sv
// nth_gf2_irreducible_sieve: returns the nth XOR prime (irreducible GF(2)
// polynomial as an integer, bit k = coefficient of x^k), counting 2 as the
// first. Each query word runs a full sieve over the values below 2^16:
// first a clearing pass sets the mark of every odd value, then odd
// candidates from 3 up are read from the bitmap; each surviving one is
// counted and, unless it is the answer, its carry-less multiples i*j (odd
// j >= i, below the bound) are struck, one product per cycle from the
// single carry-less multiplier. There are 4719 odd primes below the bound.
// Index 0 and index 1 skip the sieve and answer directly. The block
// takes one query at a time: req_tready is high only while the sequencer
// is idle. The result sits in an output register, so a new query may be
// taken while the last result still waits on rsp_tready. found (tuser)
// is 0 with value 0 when n is 0 or when fewer than n primes lie below
// the bound.
// Depends on gf2s_pkg, gf2s_clmul, gf2s_mark_ram.
module nth_gf2_irreducible_sieve
   import gf2s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] nth_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] prime_value
   output logic        rsp_tuser    // [0] found
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_INIT      = 3'd1;
   localparam logic [2:0] ST_SCAN_RD   = 3'd2;
   localparam logic [2:0] ST_SCAN_TEST = 3'd3;
   localparam logic [2:0] ST_STRIKE    = 3'd4;
   localparam logic [2:0] ST_RESULT    = 3'd5;

   localparam logic [ADDR_BITS:0] SieveEnd = (ADDR_BITS+1)'(1) << ADDR_BITS;

   logic [2:0]         state_ff, state_in;
   value_type          n_ff, n_in;
   count_type          cnt_ff, cnt_in;
   logic [ADDR_BITS:0] i_ff, i_in;      // one extra bit to see the bound
   addr_type           j_ff, j_in;
   half_type           k_ff, k_in;      // clearing pass pointer
   value_type          res_val_ff, res_val_in;
   logic               res_found_ff, res_found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   value_type          rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   mark_wr_type mark_wr;
   logic        mark_rd;
   prod_type    prod;
   logic        prod_over;
   count_type   cnt_next;
   logic        rsp_free;

   gf2s_clmul u_clmul (
      .a    (i_ff[ADDR_BITS-1:0]),
      .b    (j_ff),
      .prod (prod)
   );

   gf2s_mark_ram u_marks (
      .clock      (clock),
      .wr         (mark_wr),
      .rd_addr    (i_ff[ADDR_BITS-1:1]),
      .rd_data_ff (mark_rd)
   );

   assign prod_over = |prod[PROD_BITS-1:ADDR_BITS];
   assign cnt_next  = cnt_ff + 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // bitmap writes: fill during the clearing pass, strike during the product loop
   always_comb begin
      mark_wr.en   = 1'b0;
      mark_wr.addr = k_ff;
      mark_wr.data = 1'b1;
      if (state_ff == ST_INIT) begin
         mark_wr.en = 1'b1;
      end else if (state_ff == ST_STRIKE && !prod_over) begin
         mark_wr.en   = 1'b1;
         mark_wr.addr = prod[ADDR_BITS-1:1];
         mark_wr.data = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      res_val_in   = res_val_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               n_in   = req_tdata;
               k_in   = '0;
               i_in   = (ADDR_BITS+1)'(3);
               cnt_in = '0;
               if (req_tdata == '0) begin
                  res_val_in   = '0;
                  res_found_in = 1'b0;
                  state_in     = ST_RESULT;
               end else if (req_tdata == VALUE_BITS'(1)) begin
                  res_val_in   = VALUE_BITS'(2);
                  res_found_in = 1'b1;
                  state_in     = ST_RESULT;
               end else begin
                  cnt_in   = COUNT_BITS'(1);   // 2 counts as the first prime
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            k_in = k_ff + 1'b1;
            if (&k_ff) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            // i is odd, so the bound shows as the first value past it
            if (i_ff >= SieveEnd) begin
               res_val_in   = '0;
               res_found_in = 1'b0;
               state_in     = ST_RESULT;
            end else begin
               state_in = ST_SCAN_TEST;
            end
         end
         ST_SCAN_TEST: begin
            if (mark_rd) begin
               cnt_in = cnt_next;
               if (cnt_next == {1'b0, n_ff}) begin
                  res_val_in   = VALUE_BITS'(i_ff);
                  res_found_in = 1'b1;
                  state_in     = ST_RESULT;
               end else begin
                  j_in     = i_ff[ADDR_BITS-1:0];
                  state_in = ST_STRIKE;
               end
            end else begin
               i_in     = i_ff + 2'd2;
               state_in = ST_SCAN_RD;
            end
         end
         ST_STRIKE: begin
            if (prod_over) begin
               i_in     = i_ff + 2'd2;
               state_in = ST_SCAN_RD;
            end else begin
               j_in = j_ff + 2'd2;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_val_ff;
               rsp_user_in  = res_found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      res_val_ff   <= res_val_in;
      res_found_ff <= res_found_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> rtl/core/gf2s_checker.sv
// Port-level checks for the GF(2) sieve, bound to the top level.
// Depends on nth_gf2_irreducible_sieve_defines.svh.
`include "nth_gf2_irreducible_sieve_defines.svh"

module gf2s_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result word holds
   `GF2S_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one query at a time: busy right after a query is taken
   `GF2S_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // not found reads as value zero
   `GF2S_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 16'd0)

   // every prime but x itself has a constant term
   `GF2S_ASSERT_NOW(a_hit_shape, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[0] || rsp_tdata == 16'd2)

endmodule

bind nth_gf2_irreducible_sieve gf2s_checker u_gf2s_checker (.*);

>>> bench/sieve_scoreboard_pkg.sv
// Scoreboard for the GF(2) irreducible sieve bench: XOR prime table and answer queue.
// Depends on gf2s_pkg for the sieve bound and the value width.
package sieve_scoreboard_pkg;
   import gf2s_pkg::*;

   typedef struct {
      value_type prime_value;
      logic      found;
   } sieve_answer_type;

   class sieve_scoreboard;
      value_type        xor_primes[$];   // all XOR primes below the bound, 2 first
      sieve_answer_type answers_due[$];
      int               mismatches;

      // One sieve pass up front. A candidate's fate depends only on the primes
      // below it, so every query's answer is an index into this table.
      function new();
         bit              marks[];
         int unsigned     bound;
         int unsigned     i;
         int unsigned     j;
         int unsigned     k;
         longint unsigned prod;
         longint unsigned shifted;
         bound = 32'd1 << ADDR_BITS;
         marks = new[bound];
         for (i = 0; i < bound; i++) marks[i] = i[0];
         marks[1] = 1'b0;
         mismatches = 0;
         xor_primes.push_back(value_type'(2));
         for (i = 3; i < bound; i += 2) begin
            if (marks[i]) begin
               xor_primes.push_back(value_type'(i));
               j = i;
               while (1) begin
                  prod    = 0;
                  shifted = i;
                  k       = j;
                  while (k != 0) begin
                     if (k[0]) prod ^= shifted;
                     shifted <<= 1;
                     k >>= 1;
                  end
                  if (prod >= bound) break;
                  marks[prod] = 1'b0;
                  j += 2;
               end
            end
         end
      endfunction

      function void note_query(logic [15:0] nth);
         sieve_answer_type answer;
         if (nth == 0 || nth > xor_primes.size()) begin
            answer.prime_value = '0;
            answer.found       = 1'b0;
         end else begin
            answer.prime_value = xor_primes[nth - 1];
            answer.found       = 1'b1;
         end
         answers_due.push_back(answer);
      endfunction

      function void check_result(logic [15:0] prime_value, logic found);
         sieve_answer_type answer;
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected result word, value %0d found %0b",
                     $time, prime_value, found);
            mismatches++;
            return;
         end
         answer = answers_due.pop_front();
         if (prime_value !== answer.prime_value) begin
            $display("%0t: prime_value mismatch, expected %0d actual %0d",
                     $time, answer.prime_value, prime_value);
            mismatches++;
         end
         if (found !== answer.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, answer.found, found);
            mismatches++;
         end
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

endpackage

>>> bench/nth_gf2_irreducible_sieve_test.sv
// Top-level bench for nth_gf2_irreducible_sieve: directed and random index queries,
// random idling on both streams, a long receiver hold-off. Depends on gf2s_pkg,
// sieve_scoreboard_pkg and the sieve RTL.
module nth_gf2_irreducible_sieve_test;
   import gf2s_pkg::*;
   import sieve_scoreboard_pkg::*;

   localparam int HOLD_CYCLES  = 400;  // receiver hold-off; far longer than a trivial query
   localparam int RANDOM_WORDS = 75;
   localparam int DRAIN_CYCLES = 50;   // quiet time after the last answer, catches extra words

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] nth_index
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [15:0] prime_value
   logic        rsp_tuser;    // [0] found

   sieve_scoreboard sb;

   bit calm;            // no idling on either side while set
   bit hold_request;    // sender asks the receiver for a long hold-off
   bit holding;         // receiver is in its hold-off

   nth_gf2_irreducible_sieve i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Hang guard. Worst case is ~100 words each running the full bound
   // plus stalls; this allows several times that.
   initial begin
      #1_000_000_000;
      $display("nth_gf2_irreducible_sieve_test failed");
      $finish;
   end

   // Result monitor: values seen here are the ones present at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Receiver: ready about 66 percent of the time, steady while calm, and one long
   // hold-off on request so the output register fills and the block backs up.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !holding) begin
            holding = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            holding      = 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 34);
         end
      end
   end

   // One query word. Random idle cycles first (valid low), then hold valid
   // until the block takes the word. At most one assignment to valid per edge.
   task automatic send_query(input logic [15:0] nth);
      while (!calm && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= nth;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_query(nth);
   endtask

   initial begin
      int          table_size;
      logic [15:0] nth;
      int          pick;

      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      calm         = 1'b0;
      hold_request = 1'b0;
      holding      = 1'b0;
      sb           = new();
      table_size   = sb.xor_primes.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: index zero, index one, the first few primes, the last
      // prime of several degrees, the last prime below the bound, the first
      // index past it, and the all-ones index (bound exhausted).
      send_query(16'd0);
      send_query(16'd1);
      send_query(16'd2);
      send_query(16'd3);
      send_query(16'd4);
      send_query(16'd5);
      send_query(16'd6);
      send_query(16'd8);
      send_query(16'd14);
      send_query(16'd41);
      send_query(16'd127);
      send_query(16'd128);
      send_query(16'd747);
      send_query(16'd1000);
      send_query(16'd0);
      send_query(16'd1);
      send_query(16'(table_size));
      send_query(16'(table_size + 1));
      send_query(16'hFFFF);
      req_tvalid <= 1'b0;

      // Back-pressure: once the long queries are answered, the receiver
      // stalls while trivial queries keep coming; one answer parks in the
      // output register, the next query finishes behind it and req_tready
      // stays low until the stall ends.
      while (sb.pending() != 0) @(posedge clock);
      hold_request = 1'b1;
      while (!holding) @(posedge clock);
      repeat (6) send_query(16'($urandom_range(1)));

      // Random: mostly small indexes (each above 1 still pays the clearing
      // pass), some mid range, a few across the full 16 bits.
      for (int w = 0; w < RANDOM_WORDS; w++) begin
         calm = (w >= 40 && w < 60);
         pick = $urandom_range(99);
         if (pick < 30)      nth = 16'($urandom_range(1));
         else if (pick < 90) nth = 16'($urandom_range(300, 2));
         else if (pick < 97) nth = 16'($urandom_range(2500, 301));
         else                nth = 16'($urandom);
         send_query(nth);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("nth_gf2_irreducible_sieve_test passed");
      end else begin
         $display("nth_gf2_irreducible_sieve_test failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/gf2s_pkg.sv
rtl/core/gf2s_clmul.sv
rtl/core/gf2s_mark_ram.sv
rtl/core/nth_gf2_irreducible_sieve.sv
rtl/core/gf2s_checker.sv
bench/sieve_scoreboard_pkg.sv
bench/nth_gf2_irreducible_sieve_test.sv
